// ===== hdl/a2oli_pkg.sv =====
// Package with types, constants and the arctangent table for the atan2 pipeline.
package a2oli_pkg;

    localparam int COORD_W     = 31;
    localparam int QUO_W       = 31;
    localparam int IDX_W       = 7;
    localparam int SUB_MAX_W   = 24;
    localparam int ANGLE_W     = 15;
    localparam int FRAC_W      = 5;
    localparam int DIV_STAGES  = 31;
    localparam logic [FRAC_W-1:0]  FRAC_MIN    = 5'd7;
    localparam logic [FRAC_W-1:0]  FRAC_RESET  = 5'd16;
    localparam logic [FRAC_W-1:0]  FRAC_TOP    = 5'd31;
    localparam logic [ANGLE_W-1:0] ANGLE_PI    = 15'h4000;

    // Arctangent over the first octant, pi/4 = 0x8000.
    localparam logic [15:0] ATAN_LUT [0:128] = '{
        16'h0000,16'h0146,16'h028C,16'h03D2,16'h0517,16'h065D,16'h07A2,16'h08E7,
        16'h0A2C,16'h0B71,16'h0CB5,16'h0DF9,16'h0F3C,16'h107F,16'h11C1,16'h1303,
        16'h1444,16'h1585,16'h16C5,16'h1804,16'h1943,16'h1A80,16'h1BBD,16'h1CFA,
        16'h1E35,16'h1F6F,16'h20A9,16'h21E1,16'h2319,16'h2450,16'h2585,16'h26BA,
        16'h27ED,16'h291F,16'h2A50,16'h2B80,16'h2CAF,16'h2DDC,16'h2F08,16'h3033,
        16'h315D,16'h3285,16'h33AC,16'h34D2,16'h35F6,16'h3719,16'h383A,16'h395A,
        16'h3A78,16'h3B95,16'h3CB1,16'h3DCB,16'h3EE4,16'h3FFB,16'h4110,16'h4224,
        16'h4336,16'h4447,16'h4556,16'h4664,16'h4770,16'h487A,16'h4983,16'h4A8B,
        16'h4B90,16'h4C94,16'h4D96,16'h4E97,16'h4F96,16'h5093,16'h518F,16'h5289,
        16'h5382,16'h5478,16'h556E,16'h5661,16'h5753,16'h5843,16'h5932,16'h5A1E,
        16'h5B0A,16'h5BF3,16'h5CDB,16'h5DC1,16'h5EA6,16'h5F89,16'h606A,16'h614A,
        16'h6228,16'h6305,16'h63E0,16'h64B9,16'h6591,16'h6667,16'h673B,16'h680E,
        16'h68E0,16'h69B0,16'h6A7E,16'h6B4B,16'h6C16,16'h6CDF,16'h6DA8,16'h6E6E,
        16'h6F33,16'h6FF7,16'h70B9,16'h717A,16'h7239,16'h72F6,16'h73B3,16'h746D,
        16'h7527,16'h75DF,16'h7695,16'h774A,16'h77FE,16'h78B0,16'h7961,16'h7A10,
        16'h7ABF,16'h7B6B,16'h7C17,16'h7CC1,16'h7D6A,16'h7E11,16'h7EB7,16'h7F5C,
        16'h8000
    };

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic              xneg;
        logic [2:0]        octant;
        logic [31:0]       den;
        logic [31:0]       rem;
        logic [QUO_W-1:0]  quo;
    } div_stage_t;

    // One restoring division step: one quotient bit.
    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t  r;
        logic [32:0] rem2;
        logic [32:0] diff;
        r    = s;
        rem2 = {s.rem, 1'b0};
        diff = rem2 - {1'b0, s.den};
        if (!diff[32])
        begin
            r.rem = diff[31:0];
            r.quo = {s.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = rem2[31:0];
            r.quo = {s.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== hdl/atan2_octant_lut_interp_top.sv =====
// Top level of the pipelined atan2 unit: octant fold, divider, table and interpolation.
// An accepted request passes 1 fold stage, 31 divider stages and the table,
// multiply and output stages; throughput is one request per cycle unless the output stalls.
// The restoring divider yields one quotient bit per stage, which sets the depth.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears every valid bit and sets the fraction
// register to 16.
module atan2_octant_lut_interp_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [30:0] y_coord, [61:31] x_coord, [63:62] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [14:0] angle, [15] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data   // [4:0] ratio_fraction_bits
);
    import a2oli_pkg::*;

    // The pipeline advances whenever the output register is free or being taken.
    logic en;
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    logic [FRAC_W-1:0] frac_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frac_reg <= FRAC_RESET;
        else if (cfg_valid)
            frac_reg <= cfg_data;
    end

    // Octant fold: rotate the point so that 0 <= y < x.
    logic signed [32:0] y0, x0, y1, x1, y2, x2, y3, x3;
    logic [2:0]         oct_next;
    div_stage_t         fold_next;

    always_comb
    begin
        y0 = {{2{s_tdata[30]}}, s_tdata[30:0]};
        x0 = {{2{s_tdata[61]}}, s_tdata[61:31]};
        oct_next = 3'd0;
        y1 = y0;
        x1 = x0;
        if (y0 < 0)
        begin
            y1 = -y0;
            x1 = -x0;
            oct_next = oct_next + 3'd4;
        end
        y2 = y1;
        x2 = x1;
        if (x1 <= 0)
        begin
            x2 = y1;
            y2 = -x1;
            oct_next = oct_next + 3'd2;
        end
        y3 = y2;
        x3 = x2;
        if (x2 <= y2)
        begin
            y3 = y2 - x2;
            x3 = x2 + y2;
            oct_next = oct_next + 3'd1;
        end
        fold_next.valid  = s_tvalid;
        fold_next.zero   = (y0 == 0);
        fold_next.xneg   = x0[32];
        fold_next.octant = oct_next;
        fold_next.den    = x3[31:0];
        fold_next.rem    = y3[31:0];
        fold_next.quo    = '0;
    end

    // Stage 0 holds the folded point; stages 1..31 each add one quotient bit,
    // giving floor(y * 2^31 / x) in the last stage.
    div_stage_t div_reg [0:DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_reg[0].valid <= 1'b0;
        else if (en)
            div_reg[0] <= fold_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DIV_STAGES; gi++)
        begin : g_div
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    div_reg[gi+1].valid <= 1'b0;
                else if (en)
                    div_reg[gi+1] <= div_step(div_reg[gi]);
            end
        end
    endgenerate

    // Table stage. The top seven quotient bits index the table whatever the
    // fraction setting; the interpolation weight is the quotient rescaled.
    div_stage_t         dq;
    logic [FRAC_W-1:0]  frac_c;
    logic [FRAC_W-1:0]  sub_next;
    logic [IDX_W-1:0]   idx;
    logic [15:0]        fa_next, fb;
    logic [SUB_MAX_W-1:0] h_next;

    assign dq       = div_reg[DIV_STAGES];
    assign frac_c   = (frac_reg < FRAC_MIN) ? FRAC_MIN : frac_reg;
    assign sub_next = frac_c - FRAC_MIN;
    assign idx      = dq.quo[QUO_W-1 -: IDX_W];
    assign fa_next  = ATAN_LUT[{1'b0, idx}];
    assign fb       = ATAN_LUT[{1'b0, idx} + 8'd1];
    assign h_next   = dq.quo[SUB_MAX_W-1:0] >> (FRAC_TOP - frac_c);

    logic                 t_valid_reg, t_zero_reg, t_xneg_reg;
    logic [2:0]           t_oct_reg;
    logic [FRAC_W-1:0]    t_sub_reg;
    logic [15:0]          t_fa_reg, t_diff_reg;
    logic [SUB_MAX_W-1:0] t_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_valid_reg <= 1'b0;
        else if (en)
            t_valid_reg <= dq.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_zero_reg <= dq.zero;
            t_xneg_reg <= dq.xneg;
            t_oct_reg  <= dq.octant;
            t_sub_reg  <= sub_next;
            t_fa_reg   <= fa_next;
            t_diff_reg <= fb - fa_next;
            t_h_reg    <= h_next;
        end
    end

    // Multiply stage: slope times weight.
    logic                 p_valid_reg, p_zero_reg, p_xneg_reg;
    logic [2:0]           p_oct_reg;
    logic [FRAC_W-1:0]    p_sub_reg;
    logic [15:0]          p_fa_reg;
    logic [39:0]          p_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= t_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_zero_reg <= t_zero_reg;
            p_xneg_reg <= t_xneg_reg;
            p_oct_reg  <= t_oct_reg;
            p_sub_reg  <= t_sub_reg;
            p_fa_reg   <= t_fa_reg;
            p_prod_reg <= 40'(t_diff_reg) * 40'(t_h_reg);
        end
    end

    // Output stage: interpolate, scale to binary angle and add the octant offset, or give 0 or pi when y is zero.
    logic [39:0]        step_sh;
    logic [16:0]        interp;
    logic [15:0]        sum;
    logic [ANGLE_W-1:0] angle_next;

    always_comb
    begin
        step_sh = p_prod_reg >> p_sub_reg;
        interp  = {1'b0, p_fa_reg} + step_sh[16:0];
        sum     = {1'b0, p_oct_reg, 12'h000} + {2'b00, interp[16:3]};
        if (p_zero_reg)
            angle_next = p_xneg_reg ? ANGLE_PI : '0;
        else
            angle_next = sum[ANGLE_W-1:0];
    end

    logic [ANGLE_W-1:0] angle_reg;
    logic               out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= p_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, angle_reg};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the pipelined atan2 unit with octant fold and table interpolation.
`timescale 1ns / 1ps

module testbench;
    import a2oli_pkg::*;

    // Clock and reset.
    logic        clk;
    logic        rst_n;

    // Request stream: the y and x coordinates of one vector.
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [30:0] y_coord, [61:31] x_coord, [63:62] zero

    // Result stream: one binary angle for each request.
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [14:0] angle, [15] zero

    // Configuration channel for the fraction bits of the quotient.
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;  // [4:0] ratio_fraction_bits

    // Own copy of the fraction register, kept in step with every write.
    logic [FRAC_W-1:0] frac_bits_model;

    // Angles still owed by the block, oldest first.
    logic [ANGLE_W-1:0] pending_angles[$];

    int  error_count;
    bit  stall_out;      // random back-pressure on the result side
    bit  hold_results;   // long hold-off of the result side

    // Drain waits longer than a request takes to pass through the block.
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 200;
    localparam int COORD_MAX = 1073741823;

    atan2_octant_lut_interp_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // Works out the angle of one vector from the current fraction setting.
    // The fold and the division are done at 64 bits, so the most negative inputs fold safely.
    function automatic logic [ANGLE_W-1:0] predict_angle(input logic signed [30:0] yc,
                                                        input logic signed [30:0] xc);
        longint     y;
        longint     x;
        longint     t;
        int         octant;
        int         frac;
        int         sub_bits;
        longint unsigned ratio;
        longint unsigned idx;
        longint unsigned h;
        longint unsigned fa;
        longint unsigned fb;
        longint unsigned interp;
        y = yc;
        x = xc;
        octant = 0;
        if (y == 0)
            return (x >= 0) ? '0 : ANGLE_PI;
        if (y < 0)
        begin
            x = -x;
            y = -y;
            octant += 4;
        end
        if (x <= 0)
        begin
            t = x;
            x = y;
            y = -t;
            octant += 2;
        end
        if (x <= y)
        begin
            t = y - x;
            x = x + y;
            y = t;
            octant += 1;
        end
        frac = frac_bits_model;
        if (frac < 7)
            frac = 7;
        sub_bits = frac - 7;
        ratio  = (longint'(y) << frac) / longint'(x);
        idx    = (ratio >> sub_bits) & 64'h7F;
        h      = ratio & ((64'd1 << sub_bits) - 1);
        fa     = ATAN_LUT[idx];
        fb     = ATAN_LUT[idx + 1];
        interp = fa + (((fb - fa) * h) >> sub_bits);
        return ANGLE_W'(octant * 32'h1000 + (interp >> 3));
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Offers one request and holds it until it is taken. The valid line stays
    // high afterwards so that a following request can go out back to back; a
    // gap or a drain drops it.
    task automatic send_vector(input int yc, input int xc);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, 31'(xc), 31'(yc)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_angles.push_back(predict_angle(31'(yc), 31'(xc)));
    endtask

    // Waits until every owed angle has arrived, then for the pipeline to settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Writes the fraction register while the block is idle.
    task automatic write_frac_bits(input logic [FRAC_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frac_bits_model = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic int random_coord();
        case ($urandom_range(0, 5))
            0: return int'($urandom_range(0, 20)) - 10;
            1: return int'($urandom_range(0, 2 * COORD_MAX)) - COORD_MAX;
            2: return ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 65535));
            3: return $urandom_range(0, 1) ? COORD_MAX : -COORD_MAX;
            default: return int'($urandom_range(0, 2 * COORD_MAX)) - COORD_MAX;
        endcase
    endfunction

    // Result side: random stalls, a long hold-off when asked, and the check.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (pending_angles.size() == 0)
                report_mismatch($sformatf("unexpected angle %h", m_tdata[14:0]));
            else
            begin
                if (m_tdata[14:0] !== pending_angles[0])
                    report_mismatch($sformatf("angle %h, expected %h",
                                              m_tdata[14:0], pending_angles[0]));
                void'(pending_angles.pop_front());
            end
        end
        stall_out <= ($urandom_range(0, 9) < 3);
        m_tready  <= rst_n && !hold_results && !stall_out;
    end

    // Counts out the long hold-off of the result side once it is raised.
    always
    begin
        wait (hold_results);
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_results = 1'b0;
    end

    // Extremes, each octant boundary, zero y with both signs of x.
    task automatic test_directed();
        send_vector(0, 0);
        send_vector(0, 5);
        send_vector(0, -5);
        send_vector(0, -COORD_MAX);
        send_vector(0, COORD_MAX);
        send_vector(1, 1);
        send_vector(-1, 1);
        send_vector(1, -1);
        send_vector(-1, -1);
        send_vector(1, 0);
        send_vector(-1, 0);
        send_vector(COORD_MAX, COORD_MAX);
        send_vector(-COORD_MAX, -COORD_MAX);
        send_vector(COORD_MAX, -COORD_MAX);
        send_vector(-COORD_MAX, COORD_MAX);
        send_vector(1, COORD_MAX);
        send_vector(COORD_MAX, 1);
        send_vector(-COORD_MAX, 0);
        send_vector(3, 7);
        send_vector(-7, 3);
        send_vector(123456, -654321);
        send_vector(-2, -COORD_MAX);
        send_vector(715827882, -715827883);
    endtask

    task automatic test_random(input int count);
        repeat (count)
            send_vector(random_coord(), random_coord());
    endtask

    // The result side stops for a long while so the pipeline fills and stalls.
    task automatic test_backpressure();
        hold_results = 1'b1;
        test_random(60);
    endtask

    initial
    begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = FRAC_RESET;
        stall_out    = 1'b0;
        hold_results = 1'b0;
        error_count  = 0;
        frac_bits_model = FRAC_RESET;
        rst_n        = 1'b0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(80);
        write_frac_bits(5'd7);
        test_directed();
        test_random(60);
        write_frac_bits(5'd30);
        test_directed();
        test_random(60);
        write_frac_bits(5'd0);
        test_random(50);
        write_frac_bits(5'd31);
        test_random(50);
        write_frac_bits(5'd12);
        test_backpressure();
        write_frac_bits(5'd21);
        test_random(80);
        write_frac_bits(5'd16);
        test_random(60);

        wait_drained();
        if (error_count == 0)
            $display("atan2_octant_lut_interp_top test passed");
        else
            $display("atan2_octant_lut_interp_top test failed");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #2000000;
        $display("atan2_octant_lut_interp_top test failed");
        $finish;
    end

endmodule

// ===== atan2_octant_lut_interp_top.f =====
hdl/a2oli_pkg.sv
hdl/atan2_octant_lut_interp_top.sv
tb/testbench.sv
